@@ rtl/lir_pkg.sv @@
// lir_pkg: shared types and constants for the line intersection ratio block.
// No dependencies; used by lir_div_stage and line_intersection_ratio_2d.
package lir_pkg;

    // Width of the ratio result, fixed by the result format.
    localparam int RATIO_BITS = 24;

    // Control word that travels down the pipeline beside the data.
    typedef struct packed {
        logic valid;
        logic parallel;
        logic clipped;
    } t_ctl;

endpackage

@@ rtl/lir_front.sv @@
// lir_front: coordinate differences, cross products and the two determinants.
// Three register stages. Depends on nothing but its parameter.
module lir_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic signed [COORD_BITS-1:0]  i_ax0,
    input  logic signed [COORD_BITS-1:0]  i_ay0,
    input  logic signed [COORD_BITS-1:0]  i_ax1,
    input  logic signed [COORD_BITS-1:0]  i_ay1,
    input  logic signed [COORD_BITS-1:0]  i_bx0,
    input  logic signed [COORD_BITS-1:0]  i_by0,
    input  logic signed [COORD_BITS-1:0]  i_bx1,
    input  logic signed [COORD_BITS-1:0]  i_by1,
    output logic                          o_vld,
    output logic signed [2*COORD_BITS+2:0] o_num,
    output logic signed [2*COORD_BITS+2:0] o_den
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic [2:0] r_vld;

    logic signed [DW-1:0] r_dx13, r_dy34, r_dy13, r_dx34, r_dx12, r_dy12;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [SW-1:0] r_num, r_den;

    logic signed [PW-1:0] n_p0, n_p1, n_p2, n_p3;

    // Stage 1: differences, one bit wider than the coordinates.
    always_ff @(posedge i_clk) begin
        r_dx13 <= DW'(i_ax0) - DW'(i_bx0);
        r_dy34 <= DW'(i_by0) - DW'(i_by1);
        r_dy13 <= DW'(i_ay0) - DW'(i_by0);
        r_dx34 <= DW'(i_bx0) - DW'(i_bx1);
        r_dx12 <= DW'(i_ax0) - DW'(i_ax1);
        r_dy12 <= DW'(i_ay0) - DW'(i_ay1);
    end

    // Stage 2: four independent signed products.
    always_comb begin
        n_p0 = r_dx13 * r_dy34;
        n_p1 = r_dy13 * r_dx34;
        n_p2 = r_dx12 * r_dy34;
        n_p3 = r_dy12 * r_dx34;
    end

    always_ff @(posedge i_clk) begin
        r_p0 <= n_p0;
        r_p1 <= n_p1;
        r_p2 <= n_p2;
        r_p3 <= n_p3;
    end

    // Stage 3: numerator and denominator determinants.
    always_ff @(posedge i_clk) begin
        r_num <= SW'(r_p0) - SW'(r_p1);
        r_den <= SW'(r_p2) - SW'(r_p3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    assign o_vld = r_vld[2];
    assign o_num = r_num;
    assign o_den = r_den;

endmodule

@@ rtl/lir_div_stage.sv @@
// lir_div_stage: one restoring-division step that settles one quotient bit.
// Depends on lir_pkg for the quotient width and the control word.
module lir_div_stage #(
    parameter int MW  = 35,
    parameter int CW  = 59,
    parameter int BIT = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lir_pkg::t_ctl                   i_ctl,
    input  logic [CW-1:0]                   i_rem,
    input  logic [MW-1:0]                   i_den,
    input  logic [lir_pkg::RATIO_BITS-1:0]  i_quo,
    output lir_pkg::t_ctl                   o_ctl,
    output logic [CW-1:0]                   o_rem,
    output logic [MW-1:0]                   o_den,
    output logic [lir_pkg::RATIO_BITS-1:0]  o_quo
);

    logic [CW-1:0]                  w_dsh;
    logic                           w_ge;
    logic [CW-1:0]                  n_rem;
    logic [lir_pkg::RATIO_BITS-1:0] n_quo;

    lir_pkg::t_ctl                  r_ctl;
    logic [CW-1:0]                  r_rem;
    logic [MW-1:0]                  r_den;
    logic [lir_pkg::RATIO_BITS-1:0] r_quo;

    // Divisor aligned to this quotient bit; never loses bits since BIT < RATIO_BITS.
    always_comb begin
        w_dsh = CW'(i_den) << BIT;
        w_ge  = (i_rem >= w_dsh);
        n_rem = w_ge ? (i_rem - w_dsh) : i_rem;
        n_quo = i_quo;
        n_quo[BIT] = w_ge;
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= i_den;
        r_quo <= n_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

@@ rtl/line_intersection_ratio_2d.sv @@
// line_intersection_ratio_2d: crossing ratio of two 2D lines, fully pipelined.
// Depends on lir_pkg, lir_front and lir_div_stage.
//
// Usage:
//   Drive the eight coordinates of P1,P2 (line A) and P3,P4 (line B) and raise
//   start for one cycle per item. busy is tied low: the pipeline takes a new
//   item in every cycle, so one item per clock is the sustained rate.
//   Each result appears on o_ratio, o_parallel and o_clipped for exactly one
//   cycle, marked by o_done. Results leave in the order the items came in.
//   The pipeline holds one register stage per quotient bit in the divider,
//   after three stages of differences, products and determinants, one stage of
//   magnitude and zero detect, one of range check, and the output register.
//   o_ratio = floor(|num| * 2^RATIO_FRAC_BITS / |den|), unsigned Q8.16 by default.
//   A zero denominator gives o_parallel = 1 with ratio and clip both 0.
//   A quotient above the 24-bit range gives all ones and o_clipped = 1.
//   The receiver cannot stall, so no result is ever held back.
//   Reset (synchronous, active low) drops every item in flight; payload
//   registers keep whatever they held, only the control words and o_done clear.
module line_intersection_ratio_2d #(
    parameter int COORD_BITS      = 16,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_BITS-1:0]      i_ax0,
    input  logic signed [COORD_BITS-1:0]      i_ay0,
    input  logic signed [COORD_BITS-1:0]      i_ax1,
    input  logic signed [COORD_BITS-1:0]      i_ay1,
    input  logic signed [COORD_BITS-1:0]      i_bx0,
    input  logic signed [COORD_BITS-1:0]      i_by0,
    input  logic signed [COORD_BITS-1:0]      i_bx1,
    input  logic signed [COORD_BITS-1:0]      i_by1,
    output logic                              o_done,
    output logic [lir_pkg::RATIO_BITS-1:0]    o_ratio,
    output logic                              o_parallel,
    output logic                              o_clipped
);

    localparam int RB  = lir_pkg::RATIO_BITS;
    localparam int SW  = 2 * COORD_BITS + 3;   // signed determinant width
    localparam int MW  = SW;                   // magnitude width
    localparam int CW  = MW + RB;              // partial remainder width
    localparam int LAT = RB + 6;               // register stages from start to o_done

    // Front end: differences, products, determinants.
    logic                 w_fr_vld;
    logic signed [SW-1:0] w_num;
    logic signed [SW-1:0] w_den;

    lir_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_ax0   (i_ax0),
        .i_ay0   (i_ay0),
        .i_ax1   (i_ax1),
        .i_ay1   (i_ay1),
        .i_bx0   (i_bx0),
        .i_by0   (i_by0),
        .i_bx1   (i_bx1),
        .i_by1   (i_by1),
        .o_vld   (w_fr_vld),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    // Magnitudes and zero-denominator detect. Negating the most negative value
    // wraps to the same pattern, which read unsigned is the right magnitude.
    lir_pkg::t_ctl  r_mag_ctl;
    logic [MW-1:0]  r_mag_num;
    logic [MW-1:0]  r_mag_den;

    always_ff @(posedge i_clk) begin
        r_mag_num <= w_num[SW-1] ? MW'(-w_num) : MW'(w_num);
        r_mag_den <= w_den[SW-1] ? MW'(-w_den) : MW'(w_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_ctl <= '0;
        end else begin
            r_mag_ctl.valid    <= w_fr_vld;
            r_mag_ctl.parallel <= (w_den == '0);
            r_mag_ctl.clipped  <= 1'b0;
        end
    end

    // Scale the numerator and check the range: the quotient overflows the
    // result exactly when the scaled numerator reaches den * 2^RATIO_BITS.
    logic [CW-1:0]  w_scaled;
    logic [CW-1:0]  w_den_top;
    lir_pkg::t_ctl  n_rng_ctl;
    lir_pkg::t_ctl  r_rng_ctl;
    logic [CW-1:0]  r_rng_rem;
    logic [MW-1:0]  r_rng_den;

    always_comb begin
        w_scaled          = CW'(r_mag_num) << RATIO_FRAC_BITS;
        w_den_top         = {r_mag_den, {RB{1'b0}}};
        n_rng_ctl         = r_mag_ctl;
        n_rng_ctl.clipped = (w_scaled >= w_den_top);
    end

    always_ff @(posedge i_clk) begin
        r_rng_rem <= w_scaled;
        r_rng_den <= r_mag_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rng_ctl <= '0;
        end else begin
            r_rng_ctl <= n_rng_ctl;
        end
    end

    // Divider: one stage per quotient bit, most significant first.
    lir_pkg::t_ctl  w_ctl [RB+1];
    logic [CW-1:0]  w_rem [RB+1];
    logic [MW-1:0]  w_dv  [RB+1];
    logic [RB-1:0]  w_quo [RB+1];

    assign w_ctl[0] = r_rng_ctl;
    assign w_rem[0] = r_rng_rem;
    assign w_dv[0]  = r_rng_den;
    assign w_quo[0] = '0;

    for (genvar g = 0; g < RB; g++) begin : g_div
        lir_div_stage #(
            .MW  (MW),
            .CW  (CW),
            .BIT (RB - 1 - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_rem   (w_rem[g]),
            .i_den   (w_dv[g]),
            .i_quo   (w_quo[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_den   (w_dv[g+1]),
            .o_quo   (w_quo[g+1])
        );
    end

    // Output register: zero for a parallel item, all ones when clipped.
    lir_pkg::t_ctl  w_last;
    logic [RB-1:0]  n_ratio;
    logic           r_done;
    logic [RB-1:0]  r_ratio;
    logic           r_parallel;
    logic           r_clipped;

    assign w_last = w_ctl[RB];

    always_comb begin
        if (w_last.parallel) begin
            n_ratio = '0;
        end else if (w_last.clipped) begin
            n_ratio = '1;
        end else begin
            n_ratio = w_quo[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ratio    <= n_ratio;
        r_parallel <= w_last.parallel;
        r_clipped  <= w_last.clipped & ~w_last.parallel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_last.valid;
        end
    end

    assign busy       = 1'b0;
    assign o_done     = r_done;
    assign o_ratio    = r_ratio;
    assign o_parallel = r_parallel;
    assign o_clipped  = r_clipped;

`ifndef ASSERT_OFF
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result strobe without an item taken LAT cycles earlier");

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_parallel) |-> (o_ratio == '0 && !o_clipped))
        else $error("parallel result with nonzero ratio or clip flag");

    a_clip_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_clipped) |-> (o_ratio == '1))
        else $error("clipped result not saturated");

    a_range_stage_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rng_ctl.valid && r_rng_ctl.parallel) |-> r_rng_ctl.clipped)
        else $error("zero divisor not seen as out of range");
`endif

endmodule
